### hdl/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
// Holds the entry and control structs, command and status codes.
// No dependencies.
package spq_pkg;

  localparam int VALUE_W      = 32;
  localparam int PRIO_W       = 16;
  localparam int SPQ_CAPACITY = 16;
  localparam int SPQ_PRIO_BITS = 16;

  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_UNDER = 2'd2,
    ST_OVER  = 2'd3
  } status_t;

  typedef struct packed {
    logic signed [VALUE_W-1:0] value;
    logic        [PRIO_W-1:0]  prio;
  } spq_entry_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic       enq;
    logic       deq;
    spq_entry_t item;
  } spq_ctrl_t;

endpackage

### hdl/spq_cell.sv
// One storage cell of the sorted chain: an entry plus its occupied bit.
// Shifts toward the back on enqueue, toward the front on dequeue.
// Depends on spq_pkg.
module spq_cell (
  input  logic               clk,
  input  logic               rst,
  input  spq_pkg::spq_ctrl_t  ctrl,
  input  spq_pkg::spq_entry_t left_entry,
  input  logic               left_valid,
  input  logic               left_after,
  input  spq_pkg::spq_entry_t right_entry,
  input  logic               right_valid,
  output spq_pkg::spq_entry_t entry,
  output logic               valid,
  output logic               after
);
  import spq_pkg::*;

  // New item goes at or ahead of this cell when it is empty or strictly higher priority.
  assign after = !valid || (ctrl.item.prio < entry.prio);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (ctrl.enq && after) begin
      valid <= left_after ? left_valid : 1'b1;
    end else if (ctrl.deq) begin
      valid <= right_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.enq && after) begin
      // Take the neighbor's entry if the insert point lies further front.
      entry <= left_after ? left_entry : ctrl.item;
    end else if (ctrl.deq) begin
      entry <= right_entry;
    end
  end

endmodule

### hdl/sorted_priority_queue.sv
// Sorted priority queue built from a chain of compare-and-shift cells.
// The result is registered and appears in the cycle after the command transaction.
// Throughput: one command per cycle while results are taken; every cell compares and
// shifts in parallel, and a waiting result holds off new commands until it is taken.
// Reset clears all occupied bits and the output valid; stored data is not cleared.
module sorted_priority_queue #(
  parameter int CAPACITY  = spq_pkg::SPQ_CAPACITY,
  parameter int PRIO_BITS = spq_pkg::SPQ_PRIO_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              cmd,
  input  logic signed [spq_pkg::VALUE_W-1:0] value,
  input  logic        [spq_pkg::PRIO_W-1:0]  prio,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic        [1:0]                 status,
  output logic signed [spq_pkg::VALUE_W-1:0] out_value,
  output logic        [spq_pkg::PRIO_W-1:0]  out_prio
);
  import spq_pkg::*;

  localparam logic [PRIO_W-1:0] PRIO_MASK = (PRIO_BITS >= PRIO_W) ? {PRIO_W{1'b1}} :
                                            PRIO_W'((64'd1 << PRIO_BITS) - 64'd1);

  spq_entry_t          entry_a   [CAPACITY];
  spq_entry_t          left_e    [CAPACITY];
  spq_entry_t          right_e   [CAPACITY];
  logic [CAPACITY-1:0] valid_vec;
  logic [CAPACITY-1:0] after_vec;
  logic [CAPACITY-1:0] left_v;
  logic [CAPACITY-1:0] left_a;
  logic [CAPACITY-1:0] right_v;
  spq_ctrl_t           ctrl;
  logic                in_fire;
  logic                full;
  logic                empty;
  status_t             status_r;
  status_t             status_next;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign full     = valid_vec[CAPACITY-1];
  assign empty    = !valid_vec[0];

  always_comb begin
    ctrl.enq        = in_fire && (cmd == CMD_ENQ) && !full;
    ctrl.deq        = in_fire && (cmd == CMD_DEQ) && !empty;
    ctrl.item.value = value;
    ctrl.item.prio  = prio & PRIO_MASK;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left_e[i] = '0;
      assign left_v[i] = 1'b0;
      assign left_a[i] = 1'b0;
    end else begin : g_mid_l
      assign left_e[i] = entry_a[i-1];
      assign left_v[i] = valid_vec[i-1];
      assign left_a[i] = after_vec[i-1];
    end
    if (i == CAPACITY-1) begin : g_last
      assign right_e[i] = '0;
      assign right_v[i] = 1'b0;
    end else begin : g_mid_r
      assign right_e[i] = entry_a[i+1];
      assign right_v[i] = valid_vec[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .left_entry  (left_e[i]),
      .left_valid  (left_v[i]),
      .left_after  (left_a[i]),
      .right_entry (right_e[i]),
      .right_valid (right_v[i]),
      .entry       (entry_a[i]),
      .valid       (valid_vec[i]),
      .after       (after_vec[i])
    );
  end

  always_comb begin
    if (cmd == CMD_ENQ) begin
      status_next = full ? ST_OVER : ST_ENQ;
    end else begin
      status_next = empty ? ST_UNDER : ST_DEQ;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status_r <= status_next;
      if (ctrl.deq) begin
        out_value <= entry_a[0].value;
        out_prio  <= entry_a[0].prio;
      end else begin
        out_value <= '0;
        out_prio  <= '0;
      end
    end
  end

  assign status = status_r;

  // Checks on the cell chain.
  logic [CAPACITY-1:0] valid_inc;
  logic [CAPACITY-2:0] order_ok;

  assign valid_inc = valid_vec + {{(CAPACITY-1){1'b0}}, 1'b1};

  for (genvar j = 0; j < CAPACITY-1; j++) begin : g_order
    assign order_ok[j] = !valid_vec[j+1] || (entry_a[j].prio <= entry_a[j+1].prio);
  end

  a_occupancy_contiguous: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & valid_inc) == '0)
    else $error("occupied cells are not contiguous from the front");

  a_sorted: assert property (@(posedge clk) disable iff (rst)
    &order_ok)
    else $error("stored priorities out of order");

  a_enq_grows: assert property (@(posedge clk) disable iff (rst)
    ctrl.enq |=> $countones(valid_vec) == $past($countones(valid_vec)) + 1)
    else $error("enqueue did not add exactly one entry");

  a_deq_front: assert property (@(posedge clk) disable iff (rst)
    ctrl.deq |=> out_valid && (status == ST_DEQ) && (out_value == $past(entry_a[0].value)))
    else $error("dequeue did not return the front entry");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    in_fire && (cmd == CMD_DEQ) && empty |=> status == ST_UNDER)
    else $error("dequeue on empty queue not flagged");

endmodule
